FILE: src/framed_packet_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// Framed packet deframer assertion macros
// Assertion shorthands for the deframer core; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define FRAMED_PACKET_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FPD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fpd assertion failed");

// next-cycle implication
`define FPD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fpd assertion failed");

`else

`define FPD_ASSERT_IMP(lbl, ante, cons)
`define FPD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: src/fpd_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet deframer package
// Types, header layout constants and trailer length lookup.
// ----------------------------------------------------------------------------
package fpd_pkg;

   localparam int unsigned HDR_BYTES    = 14;
   localparam logic [15:0] POS_MAX      = 16'hFFFF;
   localparam logic [15:0] POS_HDR_LAST = 16'(HDR_BYTES - 1);
   localparam logic [15:0] MAGIC_WORD   = 16'hC153;
   localparam logic [7:0]  VERSION_OK   = 8'h01;

   // header byte offsets
   localparam logic [3:0] HB_MAGIC0  = 4'd0;
   localparam logic [3:0] HB_VERSION = 4'd2;
   localparam logic [3:0] HB_MODEL   = 4'd3;
   localparam logic [3:0] HB_TYPE    = 4'd4;
   localparam logic [3:0] HB_FLAGS   = 4'd5;
   localparam logic [3:0] HB_LEN_HI  = 4'd6;
   localparam logic [3:0] HB_LEN_LO  = 4'd7;
   localparam logic [3:0] HB_TIME0   = 4'd8;
   localparam logic [3:0] HB_TIME3   = 4'd11;

   localparam logic [3:0] SEC_STD    = 4'd1;
   localparam logic [3:0] SEC_HIGH_A = 4'd2;
   localparam logic [3:0] SEC_HIGH_B = 4'd3;

   localparam logic [5:0] MAC_STD  = 6'd16;
   localparam logic [5:0] MAC_HIGH = 6'd32;
   localparam logic [5:0] MAC_NONE = 6'd2;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_TRAILER = 2'd2,
      PH_IGNORE  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_HDR_SHORT   = 3'd1,
      ST_BAD_MAGIC   = 3'd2,
      ST_BAD_VERSION = 3'd3,
      ST_PAY_SHORT   = 3'd4,
      ST_MAC_SHORT   = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [7:0]  data_out;
      phase_type   section;
      logic        done_res;
      status_type  status;
      logic [7:0]  model_code;
      logic [7:0]  body_kind;
      logic [3:0]  sec_level;
      logic [15:0] payload_length;
      logic [31:0] timestamp;
      logic [15:0] reserved_field;
      logic [5:0]  mac_length;
   } result_type;

   function automatic logic [5:0] mac_len(input logic [3:0] lvl);
      case (lvl) inside
         SEC_STD:                mac_len = MAC_STD;
         SEC_HIGH_A, SEC_HIGH_B: mac_len = MAC_HIGH;
         default:                mac_len = MAC_NONE;
      endcase
   endfunction

endpackage

FILE: src/fpd_in_stage.sv
// ----------------------------------------------------------------------------
// Framed packet deframer input stage
// Registers one received word and its last flag ahead of the parser.
// ----------------------------------------------------------------------------
module fpd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_in,
   input  logic              req_last,
   input  logic              out_free,
   output logic              item_valid,
   output fpd_pkg::item_type item
);

   logic              valid_ff, valid_in;
   fpd_pkg::item_type item_ff;
   logic              accept;

   // hold the word while the result register cannot take it
   assign req_stall = valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.data <= req_data_in;
         item_ff.last <= req_last;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: src/fpd_parser.sv
// ----------------------------------------------------------------------------
// Framed packet deframer parser
// Frame state, header capture and verdict logic for one word per cycle while advance is high.
// ----------------------------------------------------------------------------
module fpd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  fpd_pkg::item_type   item,
   output fpd_pkg::result_type result
);

   logic [15:0]        pos_ff, pos_in;
   fpd_pkg::phase_type phase_ff, phase_in;
   logic [23:0]        mv_ff, mv_in;
   logic [7:0]         model_ff, model_in;
   logic [7:0]         type_ff, type_in;
   logic [7:0]         flags_ff, flags_in;
   logic [15:0]        length_ff, length_in;
   logic [31:0]        time_ff, time_in;
   logic [15:0]        reserved_ff, reserved_in;

   logic               counted;
   logic [15:0]        count;
   logic [5:0]         mac_now;
   logic [17:0]        pay_end;
   logic [17:0]        mac_end;
   logic [17:0]        count_ext;
   logic [3:0]         hdr_idx;
   logic               done;
   fpd_pkg::status_type status;

   // saturate the word counter
   assign counted   = (pos_ff != fpd_pkg::POS_MAX);
   assign count     = counted ? pos_ff + 16'd1 : pos_ff;
   assign count_ext = {2'b00, count};
   assign hdr_idx   = pos_ff[3:0];
   assign mac_now   = fpd_pkg::mac_len(flags_in[3:0]);
   assign pay_end   = 18'(fpd_pkg::HDR_BYTES) + {2'b00, length_ff};
   assign mac_end   = pay_end + {12'd0, mac_now};

   // header field capture
   always_comb begin
      mv_in       = mv_ff;
      model_in    = model_ff;
      type_in     = type_ff;
      flags_in    = flags_ff;
      length_in   = length_ff;
      time_in     = time_ff;
      reserved_in = reserved_ff;
      if (phase_ff == fpd_pkg::PH_HEADER) begin
         case (hdr_idx) inside
            [fpd_pkg::HB_MAGIC0:fpd_pkg::HB_VERSION]: mv_in = {mv_ff[15:0], item.data};
            fpd_pkg::HB_MODEL: model_in = item.data;
            fpd_pkg::HB_TYPE:  type_in  = item.data;
            fpd_pkg::HB_FLAGS: flags_in = item.data;
            [fpd_pkg::HB_LEN_HI:fpd_pkg::HB_LEN_LO]: length_in = {length_ff[7:0], item.data};
            [fpd_pkg::HB_TIME0:fpd_pkg::HB_TIME3]:   time_in   = {time_ff[23:0], item.data};
            default: reserved_in = {reserved_ff[7:0], item.data};
         endcase
      end
   end

   // next phase and verdict
   always_comb begin
      phase_in = phase_ff;
      done     = 1'b0;
      status   = fpd_pkg::ST_OK;
      unique case (phase_ff)
         fpd_pkg::PH_HEADER: begin
            if (pos_ff == fpd_pkg::POS_HDR_LAST) begin
               if (mv_ff[23:8] != fpd_pkg::MAGIC_WORD) begin
                  status   = fpd_pkg::ST_BAD_MAGIC;
                  done     = 1'b1;
                  phase_in = fpd_pkg::PH_IGNORE;
               end else if (mv_ff[7:0] != fpd_pkg::VERSION_OK) begin
                  status   = fpd_pkg::ST_BAD_VERSION;
                  done     = 1'b1;
                  phase_in = fpd_pkg::PH_IGNORE;
               end else if (length_ff != 16'd0) begin
                  phase_in = fpd_pkg::PH_PAYLOAD;
               end else begin
                  phase_in = fpd_pkg::PH_TRAILER;
               end
            end
         end
         fpd_pkg::PH_PAYLOAD: begin
            if (counted && count_ext == pay_end) begin
               phase_in = fpd_pkg::PH_TRAILER;
            end
         end
         fpd_pkg::PH_TRAILER: begin
            if (counted && count_ext == mac_end) begin
               done     = 1'b1;
               phase_in = fpd_pkg::PH_IGNORE;
            end
         end
         fpd_pkg::PH_IGNORE: begin
         end
      endcase

      // buffer ended before the frame did
      if (item.last && !done && phase_in != fpd_pkg::PH_IGNORE) begin
         done = 1'b1;
         unique case (phase_in)
            fpd_pkg::PH_HEADER:  status = fpd_pkg::ST_HDR_SHORT;
            fpd_pkg::PH_PAYLOAD: status = fpd_pkg::ST_PAY_SHORT;
            default:             status = fpd_pkg::ST_MAC_SHORT;
         endcase
         phase_in = fpd_pkg::PH_IGNORE;
      end
   end

   // result fields
   always_comb begin
      result                = '0;
      result.data_out       = item.data;
      result.section        = phase_ff;
      result.done_res       = done;
      result.status         = done ? status : fpd_pkg::ST_OK;
      if (done && (status == fpd_pkg::ST_OK || status == fpd_pkg::ST_PAY_SHORT ||
                   status == fpd_pkg::ST_MAC_SHORT)) begin
         result.model_code     = model_in;
         result.body_kind      = type_in;
         result.sec_level      = flags_in[3:0];
         result.payload_length = length_in;
         result.timestamp      = time_in;
         result.reserved_field = reserved_in;
         if (status != fpd_pkg::ST_PAY_SHORT) begin
            result.mac_length = mac_now;
         end
      end
   end

   assign pos_in = count;

   always_ff @(posedge clock) begin
      if (reset || (advance && item.last)) begin
         pos_ff      <= '0;
         phase_ff    <= fpd_pkg::PH_HEADER;
         mv_ff       <= '0;
         model_ff    <= '0;
         type_ff     <= '0;
         flags_ff    <= '0;
         length_ff   <= '0;
         time_ff     <= '0;
         reserved_ff <= '0;
      end else if (advance) begin
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         mv_ff       <= mv_in;
         model_ff    <= model_in;
         type_ff     <= type_in;
         flags_ff    <= flags_in;
         length_ff   <= length_in;
         time_ff     <= time_in;
         reserved_ff <= reserved_in;
      end
   end

endmodule

FILE: src/framed_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// Framed packet deframer core
//
//   channel  ports                        direction  carries
//   req      req_valid/req_stall          in         one received word + last
//   rsp      rsp_valid/rsp_stall          out        one parse result per word
//
// One word per cycle sustained while rsp_stall is low; a word is loaded into
// the input register and its result into the result register, and a receiver
// stall holds both in place. The frame state updates once per word in the
// parser, between the two.
// Reset is synchronous and returns the parser to the start of a frame.
// req_stall rises when both registers hold words and rsp_stall is high.
// ----------------------------------------------------------------------------
`include "framed_packet_deframer_core_defines.svh"

module framed_packet_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_in,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_out,
   output logic [1:0]  rsp_section,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_model_code,
   output logic [7:0]  rsp_body_kind,
   output logic [3:0]  rsp_sec_level,
   output logic [15:0] rsp_payload_length,
   output logic [31:0] rsp_timestamp,
   output logic [15:0] rsp_reserved_field,
   output logic [5:0]  rsp_mac_length
);

   logic                rsp_valid_ff, rsp_valid_in;
   fpd_pkg::result_type res_ff;
   fpd_pkg::result_type res_next;
   fpd_pkg::item_type   item;
   logic                item_valid;
   logic                out_free;
   logic                advance;
   logic                res_open;
   logic                res_ok;
   logic                res_hdr_err;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = item_valid && out_free;

   fpd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data_in (req_data_in),
      .req_last    (req_last),
      .out_free    (out_free),
      .item_valid  (item_valid),
      .item        (item)
   );

   fpd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (res_next)
   );

   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_next;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = res_ff.data_out;
   assign rsp_section        = res_ff.section;
   assign rsp_done_res       = res_ff.done_res;
   assign rsp_status         = res_ff.status;
   assign rsp_model_code     = res_ff.model_code;
   assign rsp_body_kind      = res_ff.body_kind;
   assign rsp_sec_level      = res_ff.sec_level;
   assign rsp_payload_length = res_ff.payload_length;
   assign rsp_timestamp      = res_ff.timestamp;
   assign rsp_reserved_field = res_ff.reserved_field;
   assign rsp_mac_length     = res_ff.mac_length;

   assign res_open    = rsp_valid_ff && !res_ff.done_res;
   assign res_ok      = rsp_valid_ff && res_ff.done_res && res_ff.status == fpd_pkg::ST_OK;
   assign res_hdr_err = rsp_valid_ff && res_ff.done_res &&
                        (res_ff.status == fpd_pkg::ST_HDR_SHORT ||
                         res_ff.status == fpd_pkg::ST_BAD_MAGIC ||
                         res_ff.status == fpd_pkg::ST_BAD_VERSION);

   `FPD_ASSERT_IMP(a_open_result_blank, res_open, res_ff.mac_length == '0 && res_ff.timestamp == '0)
   `FPD_ASSERT_IMP(a_hdr_error_blank, res_hdr_err, res_ff.mac_length == '0 && res_ff.timestamp == '0)
   `FPD_ASSERT_IMP(a_ok_ends_trailer, res_ok, res_ff.section == fpd_pkg::PH_TRAILER)
   `FPD_ASSERT_NXT(a_item_held, item_valid && !out_free, item_valid)

endmodule

FILE: tb/fpd_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet deframer result checker
// Watches both channels, runs its own frame parser on every accepted word
// and compares each accepted result, field by field, against the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module fpd_result_checker
   import fpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_in,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_data_out,
   input  logic [1:0]  rsp_section,
   input  logic        rsp_done_res,
   input  logic [2:0]  rsp_status,
   input  logic [7:0]  rsp_model_code,
   input  logic [7:0]  rsp_body_kind,
   input  logic [3:0]  rsp_sec_level,
   input  logic [15:0] rsp_payload_length,
   input  logic [31:0] rsp_timestamp,
   input  logic [15:0] rsp_reserved_field,
   input  logic [5:0]  rsp_mac_length,
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          verdicts,
   output logic [7:0]  status_seen
);

   localparam int MAX_PRINTED = 40;

   // parser copy of the frame state
   logic [15:0] pos_q;
   phase_type   phase_q;
   logic [23:0] magic_ver_q;
   logic [7:0]  model_q;
   logic [7:0]  ptype_q;
   logic [7:0]  flags_q;
   logic [15:0] len_q;
   logic [31:0] tstamp_q;
   logic [15:0] resv_q;
   status_type  stat_q;

   result_type  parse_results_q[$];

   function automatic logic [5:0] tail_bytes(input logic [3:0] lvl);
      if (lvl == SEC_STD) return MAC_STD;
      if (lvl == SEC_HIGH_A || lvl == SEC_HIGH_B) return MAC_HIGH;
      return MAC_NONE;
   endfunction

   task automatic clear_parser();
      pos_q       = '0;
      phase_q     = PH_HEADER;
      magic_ver_q = '0;
      model_q     = '0;
      ptype_q     = '0;
      flags_q     = '0;
      len_q       = '0;
      tstamp_q    = '0;
      resv_q      = '0;
      stat_q      = ST_OK;
   endtask

   task automatic advance_parser(input logic [7:0] b, input logic l, output result_type r);
      logic        counted;
      logic        done;
      int unsigned cnt;
      phase_type   sec;
      counted = (pos_q != POS_MAX);
      cnt     = counted ? pos_q + 1 : pos_q;
      done    = 1'b0;
      sec     = PH_IGNORE;
      case (phase_q)
         PH_HEADER: begin
            sec = PH_HEADER;
            if (pos_q < HB_MODEL) magic_ver_q = {magic_ver_q[15:0], b};
            else if (pos_q == HB_MODEL) model_q = b;
            else if (pos_q == HB_TYPE) ptype_q = b;
            else if (pos_q == HB_FLAGS) flags_q = b;
            else if (pos_q <= HB_LEN_LO) len_q = {len_q[7:0], b};
            else if (pos_q <= HB_TIME3) tstamp_q = {tstamp_q[23:0], b};
            else resv_q = {resv_q[7:0], b};
            // magic and version are judged only once the whole header is in
            if (pos_q == POS_HDR_LAST) begin
               if (magic_ver_q[23:8] != MAGIC_WORD) begin
                  stat_q  = ST_BAD_MAGIC;
                  done    = 1'b1;
                  phase_q = PH_IGNORE;
               end else if (magic_ver_q[7:0] != VERSION_OK) begin
                  stat_q  = ST_BAD_VERSION;
                  done    = 1'b1;
                  phase_q = PH_IGNORE;
               end else begin
                  phase_q = (len_q != 0) ? PH_PAYLOAD : PH_TRAILER;
               end
            end
         end
         PH_PAYLOAD: begin
            sec = PH_PAYLOAD;
            if (counted && cnt == HDR_BYTES + len_q) phase_q = PH_TRAILER;
         end
         PH_TRAILER: begin
            sec = PH_TRAILER;
            if (counted && cnt == HDR_BYTES + len_q + tail_bytes(flags_q[3:0])) begin
               stat_q  = ST_OK;
               done    = 1'b1;
               phase_q = PH_IGNORE;
            end
         end
         default: sec = PH_IGNORE;
      endcase

      // buffer ended before the frame was complete
      if (l && !done && phase_q != PH_IGNORE) begin
         if (phase_q == PH_HEADER) stat_q = ST_HDR_SHORT;
         else if (phase_q == PH_PAYLOAD) stat_q = ST_PAY_SHORT;
         else stat_q = ST_MAC_SHORT;
         done = 1'b1;
      end

      r          = '0;
      r.data_out = b;
      r.section  = sec;
      r.done_res = done;
      if (done) begin
         r.status = stat_q;
         if (stat_q == ST_OK || stat_q >= ST_PAY_SHORT) begin
            r.model_code     = model_q;
            r.body_kind      = ptype_q;
            r.sec_level      = flags_q[3:0];
            r.payload_length = len_q;
            r.timestamp      = tstamp_q;
            r.reserved_field = resv_q;
            if (stat_q != ST_PAY_SHORT) r.mac_length = tail_bytes(flags_q[3:0]);
         end
         phase_q = PH_IGNORE;
      end
      pos_q = cnt[15:0];
      if (l) clear_parser();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      fail_count++;
      if (fail_count <= MAX_PRINTED)
         $display("MISMATCH result %0d: %s expected %0h got %0h", checked, what, want, got);
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) report_mismatch(what, want, got);
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         clear_parser();
         parse_results_q.delete();
         fail_count  = 0;
         checked     = 0;
         verdicts    = 0;
         status_seen = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (parse_results_q.size() == 0) begin
               report_mismatch("word with nothing predicted, data_out", '0, rsp_data_out);
            end else begin
               want = parse_results_q.pop_front();
               check_field("data_out", want.data_out, rsp_data_out);
               check_field("section", want.section, rsp_section);
               check_field("done_res", want.done_res, rsp_done_res);
               check_field("status", want.status, rsp_status);
               check_field("model_code", want.model_code, rsp_model_code);
               check_field("body_kind", want.body_kind, rsp_body_kind);
               check_field("sec_level", want.sec_level, rsp_sec_level);
               check_field("payload_length", want.payload_length, rsp_payload_length);
               check_field("timestamp", want.timestamp, rsp_timestamp);
               check_field("reserved_field", want.reserved_field, rsp_reserved_field);
               check_field("mac_length", want.mac_length, rsp_mac_length);
               checked++;
               if (want.done_res) begin
                  verdicts++;
                  status_seen[want.status] = 1'b1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_parser(req_data_in, req_last, want);
            parse_results_q.push_back(want);
         end
      end
      pending <= parse_results_q.size();
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet deframer testbench
// Feeds directed and random byte buffers (good frames, cut frames, bad magic
// and version, noise) under random sender bursts and receiver stalls; the
// checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
   import fpd_pkg::*;

   localparam int RANDOM_WORDS = 1150;
   localparam int LONG_HOLD    = 150;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 100_000;

   typedef enum int {
      FK_GOOD,
      FK_CUT_TRAILER,
      FK_CUT_PAYLOAD,
      FK_CUT_HEADER,
      FK_BAD_MAGIC,
      FK_BAD_VERSION,
      FK_NOISE
   } frame_kind_type;

   typedef enum int {
      FLOW_FREE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_style_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_data_in = 8'h00;
   logic        req_last    = 1'b0;
   logic        rsp_stall   = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_data_out;
   logic [1:0]  rsp_section;
   logic        rsp_done_res;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_model_code;
   logic [7:0]  rsp_body_kind;
   logic [3:0]  rsp_sec_level;
   logic [15:0] rsp_payload_length;
   logic [31:0] rsp_timestamp;
   logic [15:0] rsp_reserved_field;
   logic [5:0]  rsp_mac_length;

   int          fail_count;
   int          pending;
   int          checked;
   int          verdicts;
   logic [7:0]  status_seen;

   int          cycle_cnt  = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   int          hold_asks  = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   framed_packet_deframer_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_in        (req_data_in),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_out       (rsp_data_out),
      .rsp_section        (rsp_section),
      .rsp_done_res       (rsp_done_res),
      .rsp_status         (rsp_status),
      .rsp_model_code     (rsp_model_code),
      .rsp_body_kind      (rsp_body_kind),
      .rsp_sec_level      (rsp_sec_level),
      .rsp_payload_length (rsp_payload_length),
      .rsp_timestamp      (rsp_timestamp),
      .rsp_reserved_field (rsp_reserved_field),
      .rsp_mac_length     (rsp_mac_length)
   );

   fpd_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_in        (req_data_in),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_out       (rsp_data_out),
      .rsp_section        (rsp_section),
      .rsp_done_res       (rsp_done_res),
      .rsp_status         (rsp_status),
      .rsp_model_code     (rsp_model_code),
      .rsp_body_kind      (rsp_body_kind),
      .rsp_sec_level      (rsp_sec_level),
      .rsp_payload_length (rsp_payload_length),
      .rsp_timestamp      (rsp_timestamp),
      .rsp_reserved_field (rsp_reserved_field),
      .rsp_mac_length     (rsp_mac_length),
      .fail_count         (fail_count),
      .pending            (pending),
      .checked            (checked),
      .verdicts           (verdicts),
      .status_seen        (status_seen)
   );

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, pending);
         $display("tb_top failed");
         $finish;
      end
   end

   // receiver: random stall styles in segments, plus long holds on request
   initial begin : receiver
      stall_style_type style;
      int              seg_left;
      int              hold_left;
      int              holds_served;
      style        = FLOW_FREE;
      seg_left     = 0;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_asks != holds_served) begin
            holds_served = hold_asks;
            hold_left    = LONG_HOLD - 1;
            rsp_stall   <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               style    = stall_style_type'($urandom_range(0, 3));
               seg_left = $urandom_range(8, 60);
            end
            seg_left--;
            case (style)
               FLOW_FREE:   rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   function automatic int trailer_words(input logic [3:0] lvl);
      if (lvl == SEC_STD) return MAC_STD;
      if (lvl == SEC_HIGH_A || lvl == SEC_HIGH_B) return MAC_HIGH;
      return MAC_NONE;
   endfunction

   // offer one word; bursts of random length with idle gaps between them
   task automatic send_word(input logic [7:0] b, input logic l);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_data_in <= b;
      req_last    <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   // header bytes come from hdr, everything after it is random; last on the end
   task automatic send_buffer(input logic [111:0] hdr, input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = (i < HDR_BYTES) ? hdr[111 - 8 * i -: 8] : 8'($urandom);
         send_word(b, i == n - 1);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_random_frame();
      frame_kind_type kind;
      int             pick;
      int             tl;
      int             n;
      logic [7:0]     m0;
      logic [7:0]     m1;
      logic [7:0]     ver;
      logic [7:0]     flags;
      logic [15:0]    len;
      logic [111:0]   hdr;
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = FK_GOOD;
      else if (pick < 52) kind = FK_CUT_TRAILER;
      else if (pick < 64) kind = FK_CUT_PAYLOAD;
      else if (pick < 74) kind = FK_CUT_HEADER;
      else if (pick < 82) kind = FK_BAD_MAGIC;
      else if (pick < 90) kind = FK_BAD_VERSION;
      else kind = FK_NOISE;

      m0    = MAGIC_WORD[15:8];
      m1    = MAGIC_WORD[7:0];
      ver   = VERSION_OK;
      flags = {4'($urandom), ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, 3))
                                                         : 4'($urandom)};
      pick = $urandom_range(0, 99);
      if (pick < 10) len = '0;
      else if (pick < 70) len = 16'($urandom_range(1, 16));
      else if (pick < 95) len = 16'($urandom_range(17, 64));
      else len = 16'($urandom_range(65, 255));
      // frames that never reach their end may carry any length
      if (kind != FK_GOOD && kind != FK_CUT_TRAILER && $urandom_range(0, 1) == 1)
         len = 16'($urandom);
      tl = trailer_words(flags[3:0]);

      case (kind)
         FK_GOOD:        n = HDR_BYTES + len + tl + $urandom_range(0, 3);
         FK_CUT_TRAILER: n = HDR_BYTES + len + $urandom_range(0, tl - 1);
         FK_CUT_PAYLOAD: begin
            if (len == 0) len = 16'd1;
            n = HDR_BYTES + $urandom_range(0, (len > 40) ? 40 : len - 1);
         end
         FK_CUT_HEADER: begin
            n = $urandom_range(1, HDR_BYTES - 1);
            if ($urandom_range(0, 1) == 1) m0 = 8'($urandom);
         end
         FK_BAD_MAGIC: begin
            if ($urandom_range(0, 1) == 1) m0 = m0 ^ 8'($urandom_range(1, 255));
            else m1 = m1 ^ 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1) == 1) ver = 8'($urandom);
            n = HDR_BYTES + $urandom_range(0, 4);
         end
         FK_BAD_VERSION: begin
            ver = 8'($urandom);
            if (ver == VERSION_OK) ver = ~VERSION_OK;
            n = HDR_BYTES + $urandom_range(0, 4);
         end
         default: n = $urandom_range(1, 24);
      endcase

      hdr = {m0, m1, ver, 8'($urandom), 8'($urandom), flags, len, 32'($urandom),
             16'($urandom)};
      if (kind == FK_NOISE) hdr = {$urandom, $urandom, $urandom, 16'($urandom)};
      send_buffer(hdr, n);
   endtask

   initial begin : stimulus
      int target;
      int frames;
      frames = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // buffer ending on the version byte, minimal good frame with extremes, lone byte
      send_buffer({MAGIC_WORD, VERSION_OK, 88'h0}, 3);
      send_buffer({MAGIC_WORD, VERSION_OK, 8'hFF, 8'h00, 8'hF0, 16'h0000, 32'hFFFF_FFFF,
                   16'h0000}, HDR_BYTES + MAC_NONE + 1);
      send_buffer({8'hFF, 104'h0}, 1);
      wait_idle();

      // long receiver hold while words keep coming
      hold_asks <= hold_asks + 1;
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         send_random_frame();
         frames++;
         if (frames % 37 == 0) wait_idle();
         if (frames == 60) hold_asks <= hold_asks + 1;
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words in %0d random frames plus a few directed buffers",
               words_sent, frames);
      $display("checked %0d results, %0d frame verdicts, status codes seen %b",
               checked, verdicts, status_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
